[rtl/fwcsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fwcsc_pkg
// Shared widths and the result record of the second-chance cache tag
// controller.
// ----------------------------------------------------------------------------
package fwcsc_pkg;

  // Stream payload widths
  localparam int unsigned AddrW      = 32;
  localparam int unsigned OutTdataW  = 40;

  // Fixed result field widths
  localparam int unsigned WayFieldW  = 2;
  localparam int unsigned SetFieldW  = 8;
  localparam int unsigned WordFieldW = 4;
  localparam int unsigned TagFieldW  = 18;

  // One result item as handed from the sequencer to the output register
  typedef struct packed {
    logic [TagFieldW-1:0]  writeback_tag;
    logic                  writeback_needed;
    logic                  fill_needed;
    logic [WordFieldW-1:0] word_offset;
    logic [SetFieldW-1:0]  set_index;
    logic [WayFieldW-1:0]  way;
    logic                  hit;
  } fwcsc_result_t;

endpackage : fwcsc_pkg
`default_nettype wire

[rtl/fwcsc_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fwcsc_store
// Per-set row storage: a metadata memory (valid, dirty, reference, fill age
// for all ways) and a tag memory. One write and one registered read a cycle.
// ----------------------------------------------------------------------------
module fwcsc_store #(
  parameter int unsigned NUM_SETS = 256,
  parameter int unsigned NUM_WAYS = 4,
  parameter int unsigned TAG_W    = 18
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rd_en_i,
  input  wire logic [$clog2(NUM_SETS)-1:0]                   rd_addr_i,
  input  wire logic                                          wr_en_i,
  input  wire logic                                          wr_tag_en_i,
  input  wire logic [$clog2(NUM_SETS)-1:0]                   wr_addr_i,
  input  wire logic [NUM_WAYS*(3+$clog2(NUM_WAYS+1))-1:0]    wr_meta_i,
  input  wire logic [NUM_WAYS*TAG_W-1:0]                     wr_tag_i,
  output logic      [NUM_WAYS*(3+$clog2(NUM_WAYS+1))-1:0]    rd_meta_o,
  output logic      [NUM_WAYS*TAG_W-1:0]                     rd_tag_o
);

  localparam int unsigned MetaW = NUM_WAYS * (3 + $clog2(NUM_WAYS + 1));
  localparam int unsigned RowTagW = NUM_WAYS * TAG_W;

  logic [MetaW-1:0]   meta_mem [NUM_SETS];
  logic [RowTagW-1:0] tag_mem  [NUM_SETS];
  logic [MetaW-1:0]   rd_meta_q;
  logic [RowTagW-1:0] rd_tag_q;

  // Write one row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      meta_mem[wr_addr_i] <= wr_meta_i;
    end
    if (wr_en_i && wr_tag_en_i) begin
      tag_mem[wr_addr_i] <= wr_tag_i;
    end
  end

  // Read one row, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_meta_q <= meta_mem[rd_addr_i];
      rd_tag_q  <= tag_mem[rd_addr_i];
    end
  end

  assign rd_meta_o = rd_meta_q;
  assign rd_tag_o  = rd_tag_q;

endmodule : fwcsc_store
`default_nettype wire

[rtl/fwcsc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fwcsc_ctrl
// Access sequencer: clears the metadata after reset, reads the set, scans the
// ways through one tag comparator, walks the fill-age order for a victim and
// writes the updated row back.
// ----------------------------------------------------------------------------
module fwcsc_ctrl #(
  parameter int unsigned NUM_SETS       = 256,
  parameter int unsigned NUM_WAYS       = 4,
  parameter int unsigned WORDS_PER_LINE = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  // access items
  input  wire logic                                          in_valid_i,
  output logic                                               in_ready_o,
  input  wire logic [fwcsc_pkg::AddrW-1:0]                   address_i,
  input  wire logic                                          is_write_i,
  // row storage
  output logic                                               rd_en_o,
  output logic      [$clog2(NUM_SETS)-1:0]                   rd_addr_o,
  output logic                                               wr_en_o,
  output logic                                               wr_tag_en_o,
  output logic      [$clog2(NUM_SETS)-1:0]                   wr_addr_o,
  output logic      [NUM_WAYS*(3+$clog2(NUM_WAYS+1))-1:0]    wr_meta_o,
  output logic      [NUM_WAYS*(32-$clog2(NUM_SETS)-$clog2(WORDS_PER_LINE*4))-1:0]
                                                             wr_tag_o,
  input  wire logic [NUM_WAYS*(3+$clog2(NUM_WAYS+1))-1:0]    rd_meta_i,
  input  wire logic [NUM_WAYS*(32-$clog2(NUM_SETS)-$clog2(WORDS_PER_LINE*4))-1:0]
                                                             rd_tag_i,
  // results
  output logic                                               res_valid_o,
  input  wire logic                                          res_ready_i,
  output fwcsc_pkg::fwcsc_result_t                           res_o
);

  import fwcsc_pkg::*;

  localparam int unsigned OffW  = $clog2(WORDS_PER_LINE * 4);
  localparam int unsigned SetW  = $clog2(NUM_SETS);
  localparam int unsigned WordW = $clog2(WORDS_PER_LINE);
  localparam int unsigned TagW  = AddrW - OffW - SetW;
  localparam int unsigned WayW  = $clog2(NUM_WAYS);
  localparam int unsigned AgeW  = $clog2(NUM_WAYS + 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_WALK   = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [SetW-1:0]                 clr_q, clr_d;
  logic [WayW-1:0]                 idx_q, idx_d;
  logic [WayW-1:0]                 pos_q, pos_d;
  logic [WayW-1:0]                 sel_way_q, sel_way_d;
  logic                            hit_q, hit_d;
  logic                            free_found_q, free_found_d;

  // item and working row (payload)
  logic [TagW-1:0]                 tag_in_q, tag_in_d;
  logic [SetW-1:0]                 set_q, set_d;
  logic [WordW-1:0]                word_q, word_d;
  logic                            wr_q, wr_d;
  logic [NUM_WAYS-1:0]             valid_q, valid_d;
  logic [NUM_WAYS-1:0]             dirty_q, dirty_d;
  logic [NUM_WAYS-1:0]             ref_q, ref_d;
  logic [NUM_WAYS-1:0][AgeW-1:0]   age_q, age_d;
  logic [NUM_WAYS-1:0][TagW-1:0]   tag_q, tag_d;

  // updated row for write-back
  logic [NUM_WAYS-1:0]             valid_n, dirty_n, ref_n;
  logic [NUM_WAYS-1:0][AgeW-1:0]   age_n;
  logic [NUM_WAYS-1:0][TagW-1:0]   tag_n;

  logic                            cmp_hit;
  logic [WayW-1:0]                 cand_way;
  logic [AgeW-1:0]                 want_age;
  logic [AgeW-1:0]                 old_age;
  logic                            wb_needed;
  logic                            upd_go;

  // Shared tag comparator, one way a cycle
  assign cmp_hit = valid_q[idx_q] && (tag_q[idx_q] == tag_in_q);

  // Way at the current position of the fill-age order
  assign want_age = AgeW'(pos_q) + AgeW'(1);
  always_comb begin
    cand_way = '0;
    for (int k = 0; k < NUM_WAYS; k++) begin
      if (age_q[k] == want_age) begin
        cand_way = WayW'(k);
      end
    end
  end

  // Build the row that the access leaves behind
  assign old_age   = age_q[sel_way_q];
  assign wb_needed = !hit_q && valid_q[sel_way_q] && dirty_q[sel_way_q];
  always_comb begin
    valid_n = valid_q;
    dirty_n = dirty_q;
    ref_n   = ref_q;
    age_n   = age_q;
    tag_n   = tag_q;
    if (hit_q) begin
      ref_n[sel_way_q] = 1'b1;
      if (wr_q) begin
        dirty_n[sel_way_q] = 1'b1;
      end
    end else begin
      for (int k = 0; k < NUM_WAYS; k++) begin
        if (WayW'(k) != sel_way_q) begin
          if (old_age == '0) begin
            if (age_q[k] != '0) begin
              age_n[k] = age_q[k] - AgeW'(1);
            end
          end else if (age_q[k] > old_age) begin
            age_n[k] = age_q[k] - AgeW'(1);
          end
        end
      end
      age_n[sel_way_q]   = AgeW'(NUM_WAYS);
      valid_n[sel_way_q] = 1'b1;
      tag_n[sel_way_q]   = tag_in_q;
      dirty_n[sel_way_q] = wr_q;
      ref_n[sel_way_q]   = 1'b0;
    end
  end

  assign upd_go = (state_q == ST_UPDATE) && res_ready_i;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    sel_way_d    = sel_way_q;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    tag_in_d     = tag_in_q;
    set_d        = set_q;
    word_d       = word_q;
    wr_d         = wr_q;
    valid_d      = valid_q;
    dirty_d      = dirty_q;
    ref_d        = ref_q;
    age_d        = age_q;
    tag_d        = tag_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SetW'(1);
        if (clr_q == SetW'(NUM_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          tag_in_d = TagW'(address_i >> (OffW + SetW));
          set_d    = SetW'(address_i >> OffW);
          word_d   = WordW'(address_i >> 2);
          wr_d     = is_write_i;
          state_d  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        valid_d      = rd_meta_i[NUM_WAYS-1:0];
        dirty_d      = rd_meta_i[2*NUM_WAYS-1:NUM_WAYS];
        ref_d        = rd_meta_i[3*NUM_WAYS-1:2*NUM_WAYS];
        age_d        = rd_meta_i[NUM_WAYS*(3+AgeW)-1:3*NUM_WAYS];
        tag_d        = rd_tag_i;
        idx_d        = '0;
        hit_d        = 1'b0;
        free_found_d = 1'b0;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmp_hit) begin
          hit_d     = 1'b1;
          sel_way_d = idx_q;
          state_d   = ST_UPDATE;
        end else begin
          // remember the lowest invalid way
          if (!valid_q[idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            sel_way_d    = idx_q;
          end
          idx_d = idx_q + WayW'(1);
          if (idx_q == WayW'(NUM_WAYS - 1)) begin
            if (free_found_q || !valid_q[idx_q]) begin
              state_d = ST_UPDATE;
            end else begin
              pos_d   = '0;
              state_d = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        // give a referenced way its second chance, stop at a clear one
        if (!ref_q[cand_way]) begin
          sel_way_d = cand_way;
          state_d   = ST_UPDATE;
        end else begin
          ref_d[cand_way] = 1'b0;
          pos_d = (pos_q == WayW'(NUM_WAYS - 1)) ? '0 : pos_q + WayW'(1);
        end
      end
      ST_UPDATE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      sel_way_q    <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      idx_q        <= idx_d;
      pos_q        <= pos_d;
      sel_way_q    <= sel_way_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
    end
  end

  // Item and working row registers
  always_ff @(posedge clk_i) begin
    tag_in_q <= tag_in_d;
    set_q    <= set_d;
    word_q   <= word_d;
    wr_q     <= wr_d;
    valid_q  <= valid_d;
    dirty_q  <= dirty_d;
    ref_q    <= ref_d;
    age_q    <= age_d;
    tag_q    <= tag_d;
  end

  // Storage port drive
  assign in_ready_o  = (state_q == ST_IDLE);
  assign rd_en_o     = (state_q == ST_IDLE) && in_valid_i;
  assign rd_addr_o   = SetW'(address_i >> OffW);
  assign wr_en_o     = (state_q == ST_CLEAR) || upd_go;
  assign wr_tag_en_o = upd_go;
  assign wr_addr_o   = (state_q == ST_CLEAR) ? clr_q : set_q;
  assign wr_meta_o   = (state_q == ST_CLEAR) ? '0 : {age_n, ref_n, dirty_n, valid_n};
  assign wr_tag_o    = tag_n;

  // Result item
  assign res_valid_o            = upd_go;
  assign res_o.hit              = hit_q;
  assign res_o.way              = WayFieldW'(sel_way_q);
  assign res_o.set_index        = SetFieldW'(set_q);
  assign res_o.word_offset      = WordFieldW'(word_q);
  assign res_o.fill_needed      = !hit_q;
  assign res_o.writeback_needed = wb_needed;
  assign res_o.writeback_tag    = wb_needed ? TagFieldW'(tag_q[sel_way_q]) : '0;

endmodule : fwcsc_ctrl
`default_nettype wire

[rtl/four_way_cache_second_chance_core.sv]
// Sequence: an accepted item's set row is read (registered) and loaded, its ways
//   scanned and, on a full-set miss, a victim walk run that wraps at most once.
// Throughput: one item at a time; the way scan (one tag compare a cycle) and the
//   victim walk (one way a cycle) and output stalls set how long each item takes.
// Reset: after rst_ni rises the metadata memory is cleared one set a cycle,
//   with s_axis_tready low.
`default_nettype none
// ----------------------------------------------------------------------------
// four_way_cache_second_chance_core
// Tag and replacement controller for a set-associative write-back cache with
// second-chance victim selection; results leave through an output register.
// ----------------------------------------------------------------------------
module four_way_cache_second_chance_core #(
  parameter int unsigned NUM_SETS       = 256,
  parameter int unsigned NUM_WAYS       = 4,
  parameter int unsigned WORDS_PER_LINE = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // access items
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [fwcsc_pkg::AddrW-1:0]        s_axis_tdata,  // address[31:0]
  input  wire logic                               s_axis_tuser,  // is_write[0]
  // result items
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // hit[0], way[2:1], set_index[10:3], word_offset[14:11], fill_needed[15],
  // writeback_needed[16], writeback_tag[34:17], zero[39:35]
  output logic      [fwcsc_pkg::OutTdataW-1:0]    m_axis_tdata
);

  import fwcsc_pkg::*;

  localparam int unsigned SetW  = $clog2(NUM_SETS);
  localparam int unsigned TagW  = AddrW - SetW - $clog2(WORDS_PER_LINE * 4);
  localparam int unsigned MetaW = NUM_WAYS * (3 + $clog2(NUM_WAYS + 1));

  logic                      rd_en;
  logic [SetW-1:0]           rd_addr;
  logic                      wr_en;
  logic                      wr_tag_en;
  logic [SetW-1:0]           wr_addr;
  logic [MetaW-1:0]          wr_meta;
  logic [MetaW-1:0]          rd_meta;
  logic [NUM_WAYS*TagW-1:0]  wr_tag;
  logic [NUM_WAYS*TagW-1:0]  rd_tag;
  logic                      res_valid;
  logic                      res_ready;
  fwcsc_result_t             res;
  fwcsc_result_t             out_q;
  logic                      out_valid_q;

  fwcsc_store #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS),
    .TAG_W    (TagW)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .wr_en_i     (wr_en),
    .wr_tag_en_i (wr_tag_en),
    .wr_addr_i   (wr_addr),
    .wr_meta_i   (wr_meta),
    .wr_tag_i    (wr_tag),
    .rd_meta_o   (rd_meta),
    .rd_tag_o    (rd_tag)
  );

  fwcsc_ctrl #(
    .NUM_SETS       (NUM_SETS),
    .NUM_WAYS       (NUM_WAYS),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .address_i   (s_axis_tdata),
    .is_write_i  (s_axis_tuser),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .wr_en_o     (wr_en),
    .wr_tag_en_o (wr_tag_en),
    .wr_addr_o   (wr_addr),
    .wr_meta_o   (wr_meta),
    .wr_tag_o    (wr_tag),
    .rd_meta_i   (rd_meta),
    .rd_tag_i    (rd_tag),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Take a new result when the output slot is empty or draining
  assign res_ready = !out_valid_q || m_axis_tready;

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - $bits(fwcsc_result_t)){1'b0}}, out_q};

endmodule : four_way_cache_second_chance_core
`default_nettype wire

[tb/sv/second_chance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_chance_checker
// Watches the access and result streams of the cache tag controller. Keeps a
// private copy of the valid, tag, dirty, reference and fill-age state per
// set and way, predicts the result of every accepted access, and compares
// each result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module second_chance_checker #(
  parameter int unsigned NUM_SETS       = 256,
  parameter int unsigned NUM_WAYS       = 4,
  parameter int unsigned WORDS_PER_LINE = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic [fwcsc_pkg::AddrW-1:0]     s_axis_tdata,  // address[31:0]
  input  wire logic                            s_axis_tuser,  // is_write[0]
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // hit[0], way[2:1], set_index[10:3], word_offset[14:11], fill_needed[15],
  // writeback_needed[16], writeback_tag[34:17], zero[39:35]
  input  wire logic [fwcsc_pkg::OutTdataW-1:0] m_axis_tdata,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o,
  output int unsigned                          hit_count_o,
  output int unsigned                          writeback_count_o
);

  import fwcsc_pkg::*;

  localparam int unsigned OffBits = $clog2(WORDS_PER_LINE * 4);
  localparam int unsigned SetBits = $clog2(NUM_SETS);
  localparam int unsigned ResultW = $bits(fwcsc_result_t);

  // Shadow of the tag store
  logic                 held_valid    [NUM_SETS][NUM_WAYS];
  logic [TagFieldW-1:0] held_tag      [NUM_SETS][NUM_WAYS];
  logic                 held_dirty    [NUM_SETS][NUM_WAYS];
  logic                 second_chance [NUM_SETS][NUM_WAYS];
  logic [3:0]           age_rank      [NUM_SETS][NUM_WAYS];  // 0 = never filled

  fwcsc_result_t pending_lookups[$];

  // Work out one access and advance the shadow state
  function automatic fwcsc_result_t predict_lookup(input logic [AddrW-1:0] addr,
                                                   input logic wr);
    fwcsc_result_t        r;
    logic [TagFieldW-1:0] tag;
    int unsigned          s, w, k, a, n, step, old;
    int unsigned          ord [NUM_WAYS];
    logic                 found, picked;
    tag    = TagFieldW'(addr >> (OffBits + SetBits));
    s      = (addr >> OffBits) % NUM_SETS;
    r      = '0;
    found  = 1'b0;
    picked = 1'b0;
    w      = NUM_WAYS;
    r.set_index   = SetFieldW'(s);
    r.word_offset = WordFieldW'((addr >> 2) % WORDS_PER_LINE);
    for (k = 0; k < NUM_WAYS; k++) begin
      if (!found && held_valid[s][k] && held_tag[s][k] == tag) begin
        w     = k;
        found = 1'b1;
      end
    end
    if (found) begin
      second_chance[s][w] = 1'b1;
      if (wr) held_dirty[s][w] = 1'b1;
    end else begin
      // lowest free way first
      for (k = 0; k < NUM_WAYS; k++) begin
        if (w == NUM_WAYS && !held_valid[s][k]) w = k;
      end
      if (w == NUM_WAYS) begin
        // order ways oldest first, ties by way number, then walk at most twice around
        n = 0;
        for (a = 0; a <= NUM_WAYS; a++) begin
          for (k = 0; k < NUM_WAYS; k++) begin
            if (age_rank[s][k] == a && n < NUM_WAYS) begin
              ord[n] = k;
              n++;
            end
          end
        end
        w = ord[0];
        for (step = 0; step < 2 * NUM_WAYS && !picked; step++) begin
          if (!second_chance[s][ord[step % NUM_WAYS]]) begin
            w      = ord[step % NUM_WAYS];
            picked = 1'b1;
          end else begin
            second_chance[s][ord[step % NUM_WAYS]] = 1'b0;
          end
        end
        if (held_dirty[s][w]) begin
          r.writeback_needed = 1'b1;
          r.writeback_tag    = held_tag[s][w];
        end
      end
      // the filled way becomes newest
      old = age_rank[s][w];
      for (k = 0; k < NUM_WAYS; k++) begin
        if (k != w) begin
          if (old == 0 ? age_rank[s][k] != 0 : age_rank[s][k] > old)
            age_rank[s][k] = 4'(age_rank[s][k] - 1);
        end
      end
      age_rank[s][w]      = 4'(NUM_WAYS);
      held_valid[s][w]    = 1'b1;
      held_tag[s][w]      = tag;
      held_dirty[s][w]    = wr;
      second_chance[s][w] = 1'b0;
      r.fill_needed       = 1'b1;
    end
    r.hit = found;
    r.way = WayFieldW'(w);
    return r;
  endfunction

  function automatic int unsigned field_mismatch(input string field,
                                                 input longint unsigned want,
                                                 input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare results first, then predict the access accepted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    fwcsc_result_t want, got;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int k = 0; k < NUM_WAYS; k++) begin
          held_valid[s][k]    = 1'b0;
          held_tag[s][k]      = '0;
          held_dirty[s][k]    = 1'b0;
          second_chance[s][k] = 1'b0;
          age_rank[s][k]      = '0;
        end
      end
      pending_lookups.delete();
      fail_count_o      = 0;
      pending_o         = 0;
      hit_count_o       = 0;
      writeback_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[ResultW-1:0];
        if (pending_lookups.size() == 0) begin
          $error("result item 0x%0h with no access outstanding", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = pending_lookups.pop_front();
          fail_count_o += field_mismatch("hit", want.hit, got.hit)
            + field_mismatch("way", want.way, got.way)
            + field_mismatch("set_index", want.set_index, got.set_index)
            + field_mismatch("word_offset", want.word_offset, got.word_offset)
            + field_mismatch("fill_needed", want.fill_needed, got.fill_needed)
            + field_mismatch("writeback_needed", want.writeback_needed,
                             got.writeback_needed)
            + field_mismatch("writeback_tag", want.writeback_tag, got.writeback_tag)
            + field_mismatch("zero pad", 0, m_axis_tdata[OutTdataW-1:ResultW]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_lookup(s_axis_tdata, s_axis_tuser);
        pending_lookups.push_back(want);
        if (want.hit) hit_count_o++;
        if (want.writeback_needed) writeback_count_o++;
      end
      pending_o = pending_lookups.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives access items into the second-chance cache tag controller: a short
// directed run through fills, hits, dirty and clean evictions and a full
// reference-bit wrap, then random accesses crowded onto a few hot sets so
// that lines are hit, refilled and evicted often. Both streams idle at
// random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import fwcsc_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 3 * 4 + 3 + 8;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned NumPhases  = 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [AddrW-1:0]     s_axis_tdata;  // address[31:0]
  logic                 s_axis_tuser;  // is_write[0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // hit[0], way[2:1], set_index[10:3], word_offset[14:11], fill_needed[15],
  // writeback_needed[16], writeback_tag[34:17], zero[39:35]
  logic [OutTdataW-1:0] m_axis_tdata;

  int unsigned          fail_count, pending, hit_count, writeback_count;
  int unsigned          sent, quiet_cycles;
  bit                   steady;
  logic [TagFieldW-1:0] tag_pool [6];
  logic [SetFieldW-1:0] hot_sets [3];

  four_way_cache_second_chance_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  second_chance_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .hit_count_o       (hit_count),
    .writeback_count_o (writeback_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [AddrW-1:0] line_addr(input logic [TagFieldW-1:0] tag_v,
                                                 input logic [SetFieldW-1:0] set_v,
                                                 input logic [5:0] off_v);
    return {tag_v, set_v, off_v};
  endfunction

  // Offer one item, hold it until accepted, then maybe idle
  task automatic send_access(input logic [AddrW-1:0] addr, input logic wr);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= wr;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom();
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drop valid and hold until every outstanding result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Result side: ready with random stalls
  initial begin : result_sink
    int unsigned hold;
    hold          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (steady || hold == 0) begin
        m_axis_tready <= 1'b1;
        hold = pick_gap();
      end else begin
        m_axis_tready <= 1'b0;
        hold--;
      end
    end
  end

  // Abort when neither stream moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL four_way_cache_second_chance_core");
      $finish;
    end
  end

  initial begin
    int unsigned phase, i;
    logic [AddrW-1:0] addr;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    steady        = 1'b0;
    sent          = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Address extremes, hit on read and on write
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'h0000_0004, 1'b0);
    send_access(32'h0000_003C, 1'b1);
    send_access(32'hFFFF_FFC0, 1'b0);
    // Fill every way of one set, odd tags dirty
    for (i = 1; i <= 4; i++)
      send_access(line_addr(TagFieldW'(i), 8'd5, 6'(i * 4)), i[0]);
    send_access(line_addr(18'd2, 8'd5, 6'd0), 1'b0);
    send_access(line_addr(18'd3, 8'd5, 6'd8), 1'b0);
    // Full set: oldest way is clear and dirty, so it is written back
    send_access(line_addr(18'd5, 8'd5, 6'd12), 1'b1);
    // Referenced ways get a second chance, a clean way goes
    send_access(line_addr(18'd6, 8'd5, 6'd16), 1'b0);
    // Every reference bit set: the walk wraps back to the oldest way
    send_access(line_addr(18'd2, 8'd5, 6'd20), 1'b0);
    send_access(line_addr(18'd3, 8'd5, 6'd24), 1'b1);
    send_access(line_addr(18'd5, 8'd5, 6'd28), 1'b0);
    send_access(line_addr(18'd6, 8'd5, 6'd32), 1'b0);
    send_access(line_addr(18'd7, 8'd5, 6'd63), 1'b0);
    wait_drained();

    // Random phases: most accesses land on a few hot sets with a small tag pool
    for (phase = 0; phase < NumPhases; phase++) begin
      steady = (phase == 2);
      for (i = 0; i < 6; i++) tag_pool[i] = TagFieldW'($urandom_range(0, 18'h3FFFF));
      for (i = 0; i < 3; i++) hot_sets[i] = SetFieldW'($urandom_range(0, 255));
      if (phase == 0) begin
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        hot_sets[0] = '0;
        hot_sets[1] = '1;
      end
      for (i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 3) == 0)
          addr = $urandom();
        else
          addr = line_addr(tag_pool[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 2)],
                           6'($urandom_range(0, 63)));
        send_access(addr, $urandom_range(0, 99) < 40);
        if (i % 64 == 63) wait_drained();
      end
      wait_drained();
    end

    steady = 1'b0;
    repeat (TailCycles) @(negedge clk_i);
    $display("Covered %0d accesses: %0d hits, %0d dirty evictions written back,",
             sent, hit_count, writeback_count);
    $display("with random idle and stall gaps on both streams and one gap-free phase.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS four_way_cache_second_chance_core");
    end else begin
      $display("FAIL four_way_cache_second_chance_core");
    end
    $finish;
  end

endmodule
